>>> hdl/mhpq_pkg.sv
// Shared types, sizes and codes for the min-heap priority queue
package mhpq_pkg;

    // sizes
    localparam int CAPACITY = 256;
    localparam int ID_COUNT = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = $clog2(ID_COUNT);
    localparam int KEY_W    = 15;
    localparam int K_W      = ADDR_W + 2;
    localparam int CMD_W    = 2;
    localparam int ST_W     = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    // read address select
    localparam logic [1:0] RD_POP  = 2'd0;
    localparam logic [1:0] RD_SCAN = 2'd1;
    localparam logic [1:0] RD_PAR  = 2'd2;
    localparam logic [1:0] RD_KIDS = 2'd3;

    // write data select
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_ENT   = 2'd1;
    localparam logic [1:0] WR_A     = 2'd2;
    localparam logic [1:0] WR_CHILD = 2'd3;

    // position register select
    localparam logic [2:0] POS_HOLD  = 3'd0;
    localparam logic [2:0] POS_CNT   = 3'd1;
    localparam logic [2:0] POS_SCAN  = 3'd2;
    localparam logic [2:0] POS_PAR   = 3'd3;
    localparam logic [2:0] POS_CHILD = 3'd4;
    localparam logic [2:0] POS_ZERO  = 3'd5;

    // working entry select
    localparam logic [1:0] ENT_HOLD = 2'd0;
    localparam logic [1:0] ENT_IN   = 2'd1;
    localparam logic [1:0] ENT_MIN  = 2'd2;
    localparam logic [1:0] ENT_B    = 2'd3;

    // entry count operation
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    // input word
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  item_id;
        logic [KEY_W-1:0] key_value;
    } mhpq_req_t;

    // result word
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  out_id;
        logic [KEY_W-1:0] out_key;
        logic [CNT_W-1:0] occupancy;
    } mhpq_rsp_t;

    // one heap slot
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } mhpq_entry_t;

    // controller to datapath
    typedef struct packed {
        logic [1:0]      rd_sel;
        logic [1:0]      wr_sel;
        logic [2:0]      pos_sel;
        logic [1:0]      ent_sel;
        logic [1:0]      cnt_op;
        logic            scan_clr;
        logic            scan_inc;
        logic            pop_load;
        logic            pick_left;
        logic            finish;
        logic            use_out;
        logic [ST_W-1:0] status;
    } mhpq_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic su_less;
        logic found;
        logic scan_end;
        logic k_lt_n;
        logic k_eq_n;
        logic right_gt;
    } mhpq_stat_t;

endpackage

>>> hdl/min_heap_priority_queue_unit.sv
// Top level of the min-heap priority queue: controller plus datapath
//
// A command word on req is taken at a clock edge where start is high and
// busy is low. Commands: push (id, key), decrease key of an id, pop minimum,
// no operation. Every command gives exactly one result word on rsp, marked
// by done for a single cycle; the receiver cannot hold it off.
// Steps from accept to done:
//   errors and no-op: answered at once; id not found: after every held slot is scanned
//   push: the new entry climbs level by level toward the root
//   pop: root and last entry fetched, hole descends to a leaf, entry climbs back
//   update: slots scanned up to the match, then as push
// Every heap level costs a read of the single slot memory (one write port, two
// registered read ports) and then a compare/write.
// One command is in work at a time; busy drops in the cycle the result is
// shown, so the next command can be taken then.
// Reset empties the queue at once (the entry count clears); slot contents
// are not cleared, as slots are only read after they were written.
module min_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  mhpq_req_t req,
    output logic      done,
    output mhpq_rsp_t rsp
);

    mhpq_ctrl_t ctl;
    mhpq_stat_t stat;

    // sequencer
    mhpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (req.cmd),
        .stat  (stat),
        .busy  (busy),
        .ctl   (ctl)
    );

    // heap storage and arithmetic
    mhpq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctl   (ctl),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

>>> hdl/mhpq_datapath.sv
// Heap datapath: slot memory, entry count, working registers and result register
module mhpq_datapath
    import mhpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mhpq_req_t  req,
    input  mhpq_ctrl_t ctl,
    output mhpq_stat_t stat,
    output logic       done,
    output mhpq_rsp_t  rsp
);

    // heap slot memory, two registered read ports
    mhpq_entry_t heap_mem [CAPACITY];
    mhpq_entry_t rd_a_reg;
    mhpq_entry_t rd_b_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    mhpq_entry_t       ent_reg, ent_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    mhpq_rsp_t         rsp_reg, rsp_next;
    logic              done_reg, done_next;

    logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
    logic [ADDR_W-1:0] parent_addr, right_idx, left_idx, child_idx;
    logic [K_W-1:0]    kid_k;
    mhpq_entry_t       child_ent, wr_data;
    logic              wr_en;

    // child and parent addresses of the current position
    assign kid_k       = K_W'({pos_reg, 1'b0}) + K_W'(2);
    assign right_idx   = ADDR_W'(kid_k);
    assign left_idx    = ADDR_W'(kid_k - K_W'(1));
    assign parent_addr = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);
    assign child_ent   = ctl.pick_left ? rd_b_reg : rd_a_reg;
    assign child_idx   = ctl.pick_left ? left_idx : right_idx;

    // status to the controller
    always_comb
    begin
        stat.full     = (count_reg == CNT_W'(CAPACITY));
        stat.empty    = (count_reg == '0);
        stat.pos_zero = (pos_reg == '0);
        stat.su_less  = (ent_reg.key < rd_a_reg.key);
        stat.found    = (scan_reg != '0) && (rd_a_reg.id == ent_reg.id);
        stat.scan_end = (scan_reg == count_reg);
        stat.k_lt_n   = (kid_k < K_W'(count_reg));
        stat.k_eq_n   = (kid_k == K_W'(count_reg));
        stat.right_gt = (rd_a_reg.key > rd_b_reg.key);
    end

    // read address select
    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_POP:
            begin
                rd_a_addr = '0;
                rd_b_addr = ADDR_W'(count_reg - CNT_W'(1));
            end
            RD_SCAN:
            begin
                rd_a_addr = ADDR_W'(scan_reg);
                rd_b_addr = ADDR_W'(scan_reg);
            end
            RD_PAR:
            begin
                rd_a_addr = parent_addr;
                rd_b_addr = parent_addr;
            end
            RD_KIDS:
            begin
                rd_a_addr = right_idx;
                rd_b_addr = left_idx;
            end
        endcase
    end

    // write data select, always at the current position
    always_comb
    begin
        wr_en = (ctl.wr_sel != WR_NONE);
        unique case (ctl.wr_sel)
            WR_NONE:  wr_data = ent_reg;
            WR_ENT:   wr_data = ent_reg;
            WR_A:     wr_data = rd_a_reg;
            WR_CHILD: wr_data = child_ent;
        endcase
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[pos_reg] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    // position register
    always_comb
    begin
        unique case (ctl.pos_sel)
            POS_CNT:   pos_next = ADDR_W'(count_reg);
            POS_SCAN:  pos_next = ADDR_W'(scan_reg - CNT_W'(1));
            POS_PAR:   pos_next = parent_addr;
            POS_CHILD: pos_next = child_idx;
            POS_ZERO:  pos_next = '0;
            default:   pos_next = pos_reg;
        endcase
    end

    // working entry
    always_comb
    begin
        unique case (ctl.ent_sel)
            ENT_HOLD: ent_next = ent_reg;
            ENT_IN:   ent_next = '{id: req.item_id, key: req.key_value};
            ENT_MIN:  ent_next = '{id: ent_reg.id,
                                   key: (rd_a_reg.key < ent_reg.key) ? rd_a_reg.key
                                                                     : ent_reg.key};
            ENT_B:    ent_next = rd_b_reg;
        endcase
    end

    // entry count and search index
    always_comb
    begin
        unique case (ctl.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase

        priority if (ctl.scan_clr)
        begin
            scan_next = '0;
        end
        else if (ctl.scan_inc)
        begin
            scan_next = scan_reg + CNT_W'(1);
        end
        else
        begin
            scan_next = scan_reg;
        end
    end

    // popped entry and result word
    always_comb
    begin
        out_id_next  = ctl.pop_load ? rd_a_reg.id  : out_id_reg;
        out_key_next = ctl.pop_load ? rd_a_reg.key : out_key_reg;
        done_next    = ctl.finish;
        if (ctl.finish)
        begin
            rsp_next.status    = ctl.status;
            rsp_next.out_id    = ctl.use_out ? out_id_reg  : '0;
            rsp_next.out_key   = ctl.use_out ? out_key_reg : '0;
            rsp_next.occupancy = count_reg;
        end
        else
        begin
            rsp_next = rsp_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            scan_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            scan_reg  <= scan_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        ent_reg     <= ent_next;
        out_id_reg  <= out_id_next;
        out_key_reg <= out_key_next;
        rsp_reg     <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> hdl/mhpq_ctrl.sv
// Heap controller: command decode and the push, search, sift and pop sequence
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] cmd,
    input  mhpq_stat_t       stat,
    output logic             busy,
    output mhpq_ctrl_t       ctl
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SRCH    = 3'd1;
    localparam logic [2:0] S_SU_RD   = 3'd2;
    localparam logic [2:0] S_SU_CMP  = 3'd3;
    localparam logic [2:0] S_POP_LD  = 3'd4;
    localparam logic [2:0] S_DN      = 3'd5;
    localparam logic [2:0] S_DN_CMP  = 3'd6;
    localparam logic [2:0] S_DN_LAST = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       pop_reg, pop_next;

    // next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        pop_next      = pop_reg;
        ctl.rd_sel    = RD_PAR;
        ctl.wr_sel    = WR_NONE;
        ctl.pos_sel   = POS_HOLD;
        ctl.ent_sel   = ENT_HOLD;
        ctl.cnt_op    = CNT_HOLD;
        ctl.scan_clr  = 1'b0;
        ctl.scan_inc  = 1'b0;
        ctl.pop_load  = 1'b0;
        ctl.pick_left = 1'b0;
        ctl.finish    = 1'b0;
        ctl.use_out   = 1'b0;
        ctl.status    = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pop_next = (cmd == CMD_POP);
                    unique case (cmd)
                        CMD_PUSH:
                        begin
                            if (stat.full)
                            begin
                                ctl.finish = 1'b1;
                                ctl.status = ST_FULL;
                            end
                            else
                            begin
                                ctl.ent_sel = ENT_IN;
                                ctl.pos_sel = POS_CNT;
                                ctl.cnt_op  = CNT_INC;
                                state_next  = S_SU_RD;
                            end
                        end
                        CMD_UPD:
                        begin
                            if (stat.empty)
                            begin
                                ctl.finish = 1'b1;
                                ctl.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                ctl.ent_sel  = ENT_IN;
                                ctl.scan_clr = 1'b1;
                                state_next   = S_SRCH;
                            end
                        end
                        CMD_POP:
                        begin
                            if (stat.empty)
                            begin
                                ctl.finish = 1'b1;
                                ctl.status = ST_EMPTY;
                            end
                            else
                            begin
                                // fetch root and last entry together
                                ctl.rd_sel = RD_POP;
                                ctl.cnt_op = CNT_DEC;
                                state_next = S_POP_LD;
                            end
                        end
                        CMD_NOP:
                        begin
                            ctl.finish = 1'b1;
                        end
                    endcase
                end
            end

            // linear search, one slot read per cycle, compare in the cycle after the read
            S_SRCH:
            begin
                ctl.rd_sel = RD_SCAN;
                priority if (stat.found)
                begin
                    ctl.pos_sel = POS_SCAN;
                    ctl.ent_sel = ENT_MIN;
                    state_next  = S_SU_RD;
                end
                else if (stat.scan_end)
                begin
                    ctl.finish = 1'b1;
                    ctl.status = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.scan_inc = 1'b1;
                end
            end

            // sift up: read parent, or place the entry at the root
            S_SU_RD:
            begin
                if (stat.pos_zero)
                begin
                    ctl.wr_sel  = WR_ENT;
                    ctl.finish  = 1'b1;
                    ctl.use_out = pop_reg;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.rd_sel = RD_PAR;
                    state_next = S_SU_CMP;
                end
            end

            // sift up: move parent down or place the entry
            S_SU_CMP:
            begin
                if (stat.su_less)
                begin
                    ctl.wr_sel  = WR_A;
                    ctl.pos_sel = POS_PAR;
                    state_next  = S_SU_RD;
                end
                else
                begin
                    ctl.wr_sel  = WR_ENT;
                    ctl.finish  = 1'b1;
                    ctl.use_out = pop_reg;
                    state_next  = S_IDLE;
                end
            end

            // pop: keep root for the result, last entry as the one to place
            S_POP_LD:
            begin
                ctl.pop_load = 1'b1;
                ctl.ent_sel  = ENT_B;
                ctl.pos_sel  = POS_ZERO;
                state_next   = S_DN;
            end

            // hole descent: read the children (only the left one is used at the end), or go to sift up at a leaf
            S_DN:
            begin
                priority if (stat.k_lt_n)
                begin
                    ctl.rd_sel = RD_KIDS;
                    state_next = S_DN_CMP;
                end
                else if (stat.k_eq_n)
                begin
                    ctl.rd_sel = RD_KIDS;
                    state_next = S_DN_LAST;
                end
                else
                begin
                    state_next = S_SU_RD;
                end
            end

            // left child only when the right key is strictly greater
            S_DN_CMP:
            begin
                ctl.pick_left = stat.right_gt;
                ctl.wr_sel    = WR_CHILD;
                ctl.pos_sel   = POS_CHILD;
                state_next    = S_DN;
            end

            S_DN_LAST:
            begin
                ctl.pick_left = 1'b1;
                ctl.wr_sel    = WR_CHILD;
                ctl.pos_sel   = POS_CHILD;
                state_next    = S_SU_RD;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pop_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pop_reg   <= pop_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> verif/tb_min_heap_priority_queue_unit.sv
// Self-checking testbench for the min-heap priority queue top level
module tb_min_heap_priority_queue_unit;
    import mhpq_pkg::*;

    localparam int     SETTLE_CYCLES = 300;
    localparam longint RUN_LIMIT     = 64'd50_000_000;
    localparam logic [ID_W-1:0]  ID_MAX  = '1;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    // heap predictor plus the words it still expects from the block
    class heap_checker;
        mhpq_entry_t slot [CAPACITY];
        int unsigned count;
        mhpq_rsp_t   expected_q [$];
        int unsigned mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        // climb toward the root while strictly below the parent key
        function void sift_up(int unsigned pos, mhpq_entry_t ent);
            int unsigned par;
            while (pos > 0)
            begin
                par = (pos - 1) / 2;
                if (!(ent.key < slot[par].key))
                    break;
                slot[pos] = slot[par];
                pos = par;
            end
            slot[pos] = ent;
        endfunction

        // take the root, walk the hole to a leaf, refill with the last entry
        function void pop_min(output mhpq_entry_t top);
            mhpq_entry_t last;
            int unsigned n, h, k, par;
            top  = slot[0];
            last = slot[count - 1];
            count--;
            n = count;
            h = 0;
            k = 2;
            while (k < n)
            begin
                if (slot[k].key > slot[k - 1].key)
                    k--;
                slot[h] = slot[k];
                h = k;
                k = 2 * k + 2;
            end
            if (k == n)
            begin
                slot[h] = slot[k - 1];
                h = k - 1;
            end
            while (h > 0)
            begin
                par = (h - 1) / 2;
                if (!(slot[par].key > last.key))
                    break;
                slot[h] = slot[par];
                h = par;
            end
            slot[h] = last;
        endfunction

        // apply an accepted command word and queue the word it should give
        function void note_command(mhpq_req_t w);
            mhpq_rsp_t   r;
            mhpq_entry_t ent;
            int unsigned h;
            r       = '0;
            ent.id  = w.item_id;
            ent.key = w.key_value;
            case (w.cmd)
                CMD_PUSH:
                begin
                    if (count >= CAPACITY)
                        r.status = ST_FULL;
                    else
                    begin
                        count++;
                        sift_up(count - 1, ent);
                    end
                end
                CMD_UPD:
                begin
                    h = 0;
                    while (h < count && slot[h].id != ent.id)
                        h++;
                    if (h == count)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        if (slot[h].key < ent.key)
                            ent.key = slot[h].key;
                        sift_up(h, ent);
                    end
                end
                CMD_POP:
                begin
                    if (count == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        pop_min(ent);
                        r.out_id  = ent.id;
                        r.out_key = ent.key;
                    end
                end
                default:
                begin
                end
            endcase
            r.occupancy = CNT_W'(count);
            expected_q.push_back(r);
        endfunction

        // compare a result word with the oldest expected one
        function void check_result(mhpq_rsp_t got);
            mhpq_rsp_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d id %0d key %0d occ %0d",
                             got.status, got.out_id, got.out_key, got.occupancy);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.out_id !== want.out_id ||
                got.out_key !== want.out_key || got.occupancy !== want.occupancy)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected status %0d id %0d key %0d occ %0d,",
                             want.status, want.out_id, want.out_key, want.occupancy,
                             " got status %0d id %0d key %0d occ %0d",
                             got.status, got.out_id, got.out_key, got.occupancy);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    mhpq_req_t req;
    logic      done;
    mhpq_rsp_t rsp;

    heap_checker hc;
    int unsigned words_sent;
    int unsigned idle_pct;

    min_heap_priority_queue_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            hc.check_result(rsp);
    end

    // present one command word, with random idle cycles ahead of it
    task automatic send_word(input mhpq_req_t w);
        logic [31:0] noise;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            noise = $urandom;
            start <= 1'b0;
            req   <= noise[$bits(mhpq_req_t)-1:0];
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= w;
        do
            @(posedge clk);
        while (busy);
        hc.note_command(w);
        words_sent++;
    endtask

    function automatic mhpq_req_t mk(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                     logic [KEY_W-1:0] key);
        mhpq_req_t w;
        w.cmd       = cmd;
        w.item_id   = id;
        w.key_value = key;
        return w;
    endfunction

    // keys: extremes, a narrow band for ties, or anything
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return ($urandom_range(0, 1) != 0) ? KEY_MAX : '0;
        if (r < 40)
            return KEY_W'($urandom_range(0, 31));
        return KEY_W'($urandom);
    endfunction

    // ids: a small pool for duplicates, extremes, or anything
    function automatic logic [ID_W-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ($urandom_range(0, 1) != 0) ? ID_MAX : '0;
        if (r < 60)
            return ID_W'($urandom_range(0, 15));
        return ID_W'($urandom);
    endfunction

    // updates mostly target an id that is held, often with a lower key
    function automatic mhpq_req_t make_word(logic [CMD_W-1:0] cmd);
        mhpq_req_t   w;
        int unsigned s;
        w = mk(cmd, pick_id(), pick_key());
        if (cmd == CMD_UPD && hc.count > 0 && $urandom_range(0, 3) != 0)
        begin
            s = $urandom_range(0, hc.count - 1);
            w.item_id = hc.slot[s].id;
            if ($urandom_range(0, 1) != 0)
                w.key_value = KEY_W'($urandom_range(0, hc.slot[s].key));
        end
        return w;
    endfunction

    // random commands with the given mix, no-op takes what is left
    task automatic run_phase(int unsigned n, int unsigned w_push, int unsigned w_upd,
                             int unsigned w_pop);
        int unsigned      r;
        logic [CMD_W-1:0] cmd;
        repeat (n)
        begin
            idle_pct = (words_sent < 520) ? 13 : (words_sent < 1040) ? 81 : 0;
            r = $urandom_range(0, 99);
            if (r < w_push)
                cmd = CMD_PUSH;
            else if (r < w_push + w_upd)
                cmd = CMD_UPD;
            else if (r < w_push + w_upd + w_pop)
                cmd = CMD_POP;
            else
                cmd = CMD_NOP;
            send_word(make_word(cmd));
        end
    endtask

    // main sequence
    initial
    begin
        hc         = new();
        words_sent = 0;
        idle_pct   = 13;
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, no-op, extremes, duplicates, ties, update corner cases
        send_word(mk(CMD_POP,  ID_MAX, KEY_MAX));
        send_word(mk(CMD_UPD,  '0, '0));
        send_word(mk(CMD_NOP,  ID_MAX, KEY_MAX));
        send_word(mk(CMD_PUSH, '0, KEY_MAX));
        send_word(mk(CMD_PUSH, ID_MAX, '0));
        send_word(mk(CMD_PUSH, 10'd5, 15'd100));
        send_word(mk(CMD_PUSH, 10'd5, 15'd100));
        send_word(mk(CMD_PUSH, 10'd6, 15'd100));
        send_word(mk(CMD_PUSH, 10'd7, 15'd99));
        send_word(mk(CMD_UPD,  10'd5, 15'd40));
        send_word(mk(CMD_UPD,  ID_MAX, KEY_MAX));
        send_word(mk(CMD_UPD,  10'd700, 15'd1));
        send_word(mk(CMD_UPD,  '0, '0));
        send_word(mk(CMD_NOP,  '0, '0));
        repeat (7)
            send_word(mk(CMD_POP, '0, '0));
        send_word(mk(CMD_PUSH, 10'd1, 15'd200));
        send_word(mk(CMD_POP,  ID_MAX, KEY_MAX));

        // mixed, fill to full, updates while full, drain past empty, mixed
        run_phase(250, 35, 30, 30);
        run_phase(400, 80, 10, 8);
        run_phase(150, 20, 70, 8);
        run_phase(400, 8, 12, 78);
        run_phase(350, 40, 25, 33);
        start <= 1'b0;

        while (hc.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (hc.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
